@@ sv/qept_pkg.sv @@
// Package for the quadrature encoder position tracker.
// Holds the word types, the register map, the limits and the transition table.
// No dependencies.
`default_nettype none

package qept_pkg;

  localparam int POS_W   = 8;
  localparam int SPEED_W = 4;
  localparam int OBJW_W  = 6;
  localparam int CNT_W   = 3;
  localparam int PINS_W  = 2;
  localparam int STEP_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_WIDTH = 2'd1;

  localparam logic [SPEED_W-1:0] SPEED_RESET = 4'd3;
  localparam logic [OBJW_W-1:0]  OBJW_RESET  = 6'd16;
  localparam logic [POS_W-1:0]   POS_RESET   = 8'd25;

  localparam logic signed [POS_W+1:0] TOP_LIMIT    = 10'sd61;
  localparam logic signed [POS_W-1:0] BOTTOM_LIMIT = 8'sd3;
  localparam logic signed [CNT_W:0]   DETENT_UP    = 4'sd3;
  localparam logic signed [CNT_W:0]   DETENT_DN    = -4'sd3;

  // moved codes
  localparam logic [1:0] MOVED_NONE = 2'd0;
  localparam logic [1:0] MOVED_UP   = 2'd1;
  localparam logic [1:0] MOVED_DOWN = 2'd2;

  typedef struct packed {
    logic                     mode;
    logic [PINS_W-1:0]        pins;
    logic                     active;
    logic signed [POS_W-1:0]  load_value;
  } in_word_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  position;
    logic [1:0]               moved;
  } out_word_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_level;
    logic [OBJW_W-1:0]  object_width;
  } cfg_regs_t;

  typedef struct packed {
    logic [PINS_W-1:0]       last_pins;
    logic signed [CNT_W-1:0] detent_count;
    logic signed [POS_W-1:0] position;
  } trk_state_t;

  // transition code {prev B,A, cur B,A} -> -1, 0, +1
  function automatic logic signed [1:0] trans_delta(input logic [3:0] code);
    logic signed [1:0] d;
    case (code)
      4'h1, 4'h7, 4'h8, 4'hE: d = -2'sd1;
      4'h2, 4'h4, 4'hB, 4'hD: d = 2'sd1;
      default:                d = 2'sd0;
    endcase
    return d;
  endfunction

  // speed_level / 3 + 2
  function automatic logic [STEP_W-1:0] step_size(input logic [SPEED_W-1:0] s);
    logic [STEP_W-1:0] r;
    case (s)
      4'd0, 4'd1, 4'd2:    r = 3'd2;
      4'd3, 4'd4, 4'd5:    r = 3'd3;
      4'd6, 4'd7, 4'd8:    r = 3'd4;
      4'd9, 4'd10, 4'd11:  r = 3'd5;
      4'd12, 4'd13, 4'd14: r = 3'd6;
      default:             r = 3'd7;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/qept_cfg.sv @@
// Configuration register file: speed level and object width.
// Depends on qept_pkg.
`default_nettype none

module qept_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [qept_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [qept_pkg::CFG_DATA_W-1:0] wr_data,
  output qept_pkg::cfg_regs_t                 regs
);
  import qept_pkg::*;

  cfg_regs_t regs_r, regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (wr_index)
        REG_SPEED_LEVEL:  regs_nxt.speed_level  = wr_data[SPEED_W-1:0];
        REG_OBJECT_WIDTH: regs_nxt.object_width = wr_data[OBJW_W-1:0];
        default:          regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.speed_level  <= SPEED_RESET;
      regs_r.object_width <= OBJW_RESET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

`default_nettype wire

@@ sv/qept_step.sv @@
// Update logic for one word: detent count, limit checks and position step.
// Combinational; depends on qept_pkg.
`default_nettype none

module qept_step (
  input  wire qept_pkg::in_word_t   word,
  input  wire qept_pkg::trk_state_t state,
  input  wire qept_pkg::cfg_regs_t  regs,
  output qept_pkg::trk_state_t      state_nxt,
  output qept_pkg::out_word_t       result
);
  import qept_pkg::*;

  logic signed [1:0]       delta;
  logic signed [CNT_W:0]   cnt;
  logic signed [POS_W+1:0] up_sum;
  logic                    up_ok;
  logic                    dn_ok;
  logic [STEP_W-1:0]       step;
  logic [1:0]              moved;

  always_comb begin
    delta  = trans_delta({state.last_pins, word.pins});
    cnt    = {state.detent_count[CNT_W-1], state.detent_count} + {{(CNT_W-1){delta[1]}}, delta};
    up_sum = {{2{state.position[POS_W-1]}}, state.position}
             + $signed({{(POS_W+2-OBJW_W){1'b0}}, regs.object_width});
    up_ok  = (up_sum <= TOP_LIMIT);
    dn_ok  = (state.position >= BOTTOM_LIMIT);
    step   = step_size(regs.speed_level);

    state_nxt = state;
    moved     = MOVED_NONE;
    if (word.mode) begin
      state_nxt.position = word.load_value;
    end else if (word.active) begin
      state_nxt.last_pins    = word.pins;
      state_nxt.detent_count = cnt[CNT_W-1:0];
      if (cnt >= DETENT_UP) begin
        state_nxt.detent_count = '0;
        if (up_ok) begin
          state_nxt.position = state.position + $signed({{(POS_W-STEP_W){1'b0}}, step});
          moved              = MOVED_UP;
        end
      end else if (cnt <= DETENT_DN) begin
        state_nxt.detent_count = '0;
        if (dn_ok) begin
          state_nxt.position = state.position - $signed({{(POS_W-STEP_W){1'b0}}, step});
          moved              = MOVED_DOWN;
        end
      end
    end
    result.position = state_nxt.position;
    result.moved    = moved;
  end

endmodule

`default_nettype wire

@@ sv/quadrature_encoder_position_tracker_top.sv @@
// Top level of the quadrature encoder position tracker.
// Depends on qept_pkg, qept_cfg and qept_step.
`default_nettype none

//  channel | ports                          | direction | word
//  --------+--------------------------------+-----------+-------------------------------
//  in      | in_valid, in_ready, in_data    | to block  | mode, pins, active, load_value
//  out     | out_valid, out_ready, out_data | from blk  | position, moved
//  cfg     | cfg_valid, cfg_ready, cfg_*    | to block  | register index + write data
//
// One word per clock sustained while out_ready stays high. An accepted word passes
// through the input register, then the update logic into the result register, where
// out_valid rises and the result can be taken.
// The tracker state advances together with the result register, so the next
// word in the input register always sees the state its predecessor left.
// Synchronous active-low reset: position 25, detent count and pins zero,
// speed level 3, object width 16. A stalled output holds both stages; the
// input register still takes a word while the output register is drained.
// cfg_ready is always high.

module quadrature_encoder_position_tracker_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output wire logic                           in_ready,
  input  wire qept_pkg::in_word_t             in_data,
  output wire logic                           out_valid,
  input  wire logic                           out_ready,
  output wire qept_pkg::out_word_t            out_data,
  input  wire logic                           cfg_valid,
  output wire logic                           cfg_ready,
  input  wire logic [qept_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [qept_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qept_pkg::*;

  logic       s1_valid_r;
  in_word_t   s1_data_r;
  logic       out_valid_r;
  out_word_t  out_data_r;
  trk_state_t state_r;
  trk_state_t state_nxt;
  out_word_t  step_out;
  cfg_regs_t  regs;
  logic       advance;

  // result register free, or being taken this cycle
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  qept_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  qept_step u_step (
    .word      (s1_data_r),
    .state     (state_r),
    .regs      (regs),
    .state_nxt (state_nxt),
    .result    (step_out)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // result register and tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r            <= 1'b0;
      state_r.last_pins      <= '0;
      state_r.detent_count   <= '0;
      state_r.position       <= POS_RESET;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_data_r <= step_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // detent count never rests at a threshold (+3 or -3), nor at -4
  a_detent_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.detent_count != 3'sd3) && (state_r.detent_count != -3'sd3)
    && (state_r.detent_count != 3'sb100))
    else $error("detent count out of range");

  // state only moves when a word passes into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_valid_r && advance) |=> $stable(state_r))
    else $error("tracker state changed without a word");

  // result position matches state left behind
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance) |=> (out_data_r.position == state_r.position))
    else $error("result position differs from tracker state");

  // input stalls only with both stages full
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with room available");

  // moved code is never the unused value
  a_moved_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.moved == MOVED_NONE || out_data_r.moved == MOVED_UP
                     || out_data_r.moved == MOVED_DOWN))
    else $error("bad moved code");
`endif

endmodule

`default_nettype wire

@@ bench/qept_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the quadrature encoder position tracker: watches the input, result and
// register write channels, tracks detent count and position, and checks every result word.
// Depends on qept_pkg.

module qept_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  qept_pkg::in_word_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  qept_pkg::out_word_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [qept_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qept_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              words_in,
  output int                              up_moves,
  output int                              down_moves,
  output int                              held_steps
);
  import qept_pkg::*;

  localparam logic MODE_LOAD = 1'b1;

  logic [PINS_W-1:0]       trk_pins;
  logic signed [CNT_W-1:0] trk_detent;
  logic signed [POS_W-1:0] trk_pos;
  logic [SPEED_W-1:0]      reg_speed;
  logic [OBJW_W-1:0]       reg_objw;
  out_word_t               expected_q [$];
  int                      words_out;

  assign pending = words_in - words_out;

  task automatic report_mismatch(input string msg);
    $display("qept_checker @%0t: %s", $time, msg);
    fail_count++;
  endtask

  // advance the tracker by one input word, return the result it should produce
  function automatic out_word_t track_word(input in_word_t w);
    out_word_t r;
    int        pos;
    int        cnt;
    int        stride;
    int        ow;
    int        delta;
    r.moved = MOVED_NONE;
    if (w.mode == MODE_LOAD) begin
      trk_pos = w.load_value;
    end else if (w.active) begin
      case ({trk_pins, w.pins})
        4'h2, 4'h4, 4'hB, 4'hD: delta = 1;
        4'h1, 4'h7, 4'h8, 4'hE: delta = -1;
        default:                delta = 0;
      endcase
      pos    = trk_pos;
      stride = int'(reg_speed) / 3 + 2;
      ow     = int'(reg_objw);
      cnt    = int'(trk_detent) + delta;
      trk_pins = w.pins;
      // limit is checked on the old position, before the step
      if (cnt >= DETENT_UP) begin
        if (pos + ow <= TOP_LIMIT) begin
          trk_pos = POS_W'(pos + stride);
          r.moved = MOVED_UP;
          up_moves++;
        end else begin
          held_steps++;
        end
        cnt = 0;
      end else if (cnt <= DETENT_DN) begin
        if (pos >= BOTTOM_LIMIT) begin
          trk_pos = POS_W'(pos - stride);
          r.moved = MOVED_DOWN;
          down_moves++;
        end else begin
          held_steps++;
        end
        cnt = 0;
      end
      trk_detent = CNT_W'(cnt);
    end
    r.position = trk_pos;
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      trk_pins   = '0;
      trk_detent = '0;
      trk_pos    = POS_RESET;
      reg_speed  = SPEED_RESET;
      reg_objw   = OBJW_RESET;
      expected_q.delete();
      words_in   <= 0;
      words_out  <= 0;
      fail_count = 0;
      up_moves   = 0;
      down_moves = 0;
      held_steps = 0;
    end else begin
      if (out_valid && out_ready) begin
        words_out <= words_out + 1;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result word pos=%0d moved=%0d with nothing pending",
                                    $signed(out_data.position), out_data.moved));
        end else begin
          want = expected_q.pop_front();
          if (out_data.position !== want.position)
            report_mismatch($sformatf("position %0d, want %0d",
                                      $signed(out_data.position), $signed(want.position)));
          if (out_data.moved !== want.moved)
            report_mismatch($sformatf("moved %0d, want %0d (position %0d)",
                                      out_data.moved, want.moved, $signed(want.position)));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPEED_LEVEL:  reg_speed = cfg_data[SPEED_W-1:0];
          REG_OBJECT_WIDTH: reg_objw  = cfg_data[OBJW_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_q.push_back(track_word(in_data));
        words_in <= words_in + 1;
      end
    end
  end

endmodule

@@ bench/tb_quadrature_encoder_position_tracker_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the quadrature encoder position tracker: drives encoder, load and
// register write words and gives the verdict. Depends on qept_pkg, qept_checker and the RTL.

module tb_quadrature_encoder_position_tracker_top;
  import qept_pkg::*;

  // word mode field
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;
  // indexes with no register behind them; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int RANDOM_PER_PHASE = 148;
  localparam int PHASES           = 6;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_word_t              in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_ready;
  logic                  out_valid;
  out_word_t             out_data;
  logic                  cfg_ready;

  int fail_count, pending, words_in, up_moves, down_moves, held_steps;

  // idle percentages for each side, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // stimulus-side copy of what the tracker last saw on the pins and of the registers,
  // only used to steer the random part toward real rotations and the limits
  logic [PINS_W-1:0]  gen_pins;
  logic [SPEED_W-1:0] cur_speed;
  logic [OBJW_W-1:0]  cur_objw;
  int                 settings_used;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quadrature_encoder_position_tracker_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  qept_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .words_in   (words_in),
    .up_moves   (up_moves),
    .down_moves (down_moves),
    .held_steps (held_steps)
  );

  // Receiver: back-pressure decided fresh every cycle. At 0% it never stalls.
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // Encoder sample word; the load_value field is don't-care here but gets random bits
  // so every bit of it toggles.
  function automatic in_word_t pin_word(input logic [PINS_W-1:0] p, input logic act);
    in_word_t w;
    w.mode       = MODE_SAMPLE;
    w.pins       = p;
    w.active     = act;
    w.load_value = 8'($urandom_range(255));
    return w;
  endfunction

  // Load word; pins and active must be ignored by the block, so they are random.
  function automatic in_word_t load_word(input logic [POS_W-1:0] v);
    in_word_t w;
    w.mode       = MODE_LOAD;
    w.pins       = 2'($urandom_range(3));
    w.active     = 1'($urandom_range(1));
    w.load_value = v;
    return w;
  endfunction

  // Gray sequence. Counting up (+1 per edge): 00 -> 10 -> 11 -> 01 -> 00.
  // Counting down is the reverse: 00 -> 01 -> 11 -> 10 -> 00.
  function automatic logic [PINS_W-1:0] next_pins(input logic [PINS_W-1:0] p, input bit up);
    logic [PINS_W-1:0] n;
    case (p)
      2'b00:   n = up ? 2'b10 : 2'b01;
      2'b10:   n = up ? 2'b11 : 2'b00;
      2'b11:   n = up ? 2'b01 : 2'b10;
      default: n = up ? 2'b00 : 2'b11;
    endcase
    return n;
  endfunction

  // Load values: mostly right at the top limit (which moves with object_width) or the
  // bottom limit, so steps land on both sides of each check; the rest anywhere.
  function automatic logic [POS_W-1:0] pick_load();
    logic [POS_W-1:0] v;
    case ($urandom_range(3))
      0:       v = 8'(61 - int'(cur_objw) + $urandom_range(4) - 2);
      1:       v = 8'(3 + $urandom_range(4) - 2);
      2:       v = 8'($urandom_range(10, 50));
      default: v = 8'($urandom_range(255));
    endcase
    return v;
  endfunction

  // Present one word and hold it until accepted. A random gap may come first; valid is
  // lowered only inside a gap, so it never drops and rises within one time step.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait for every outstanding result word, then let the two-stage
  // pipe settle before any register is touched.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Back-to-back register writes with valid held high across them. Upper data bits
  // beyond each register's width are random and must be dropped by the block.
  task automatic write_regs(input logic [SPEED_W-1:0] spd, input logic [OBJW_W-1:0] ow,
                            input bit spares);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] dat [4];
    int                    n;
    int                    i;
    idx[0] = REG_SPEED_LEVEL;
    dat[0] = 8'(($urandom_range(255) & 8'hF0) | spd);
    idx[1] = REG_OBJECT_WIDTH;
    dat[1] = 8'(($urandom_range(255) & 8'hC0) | ow);
    n = 2;
    if (spares) begin
      idx[2] = REG_SPARE_A;
      dat[2] = 8'($urandom_range(255));
      idx[3] = REG_SPARE_B;
      dat[3] = 8'($urandom_range(255));
      n = 4;
    end
    for (i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= dat[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_speed = spd;
    cur_objw  = ow;
    settings_used++;
  endtask

  // Random traffic. Most of it is clean rotation runs (so the detent count actually
  // reaches +/-3), with contact bounce, direction changes, loads near the limits,
  // illegal two-bit jumps and inactive samples mixed in. Inactive samples are not
  // counted toward n since the tracker ignores them.
  task automatic run_random(input int n);
    int       done;
    int       r;
    int       len;
    bit       up;
    bit       paused;
    in_word_t w;
    done   = 0;
    paused = 1'b0;
    while (done < n) begin
      r = $urandom_range(99);
      if (r < 65) begin
        up  = 1'($urandom_range(1));
        len = $urandom_range(1, 9);
        repeat (len) begin
          if ($urandom_range(9) == 0) begin
            w = pin_word(gen_pins, 1'b1);         // bounce: same level again
          end else begin
            gen_pins = next_pins(gen_pins, up);
            w = pin_word(gen_pins, 1'b1);
          end
          send_word(w);
          done++;
        end
      end else if (r < 80) begin
        send_word(load_word(pick_load()));
        done++;
      end else if (r < 90) begin
        send_word(pin_word(2'($urandom_range(3)), 1'b0));
      end else begin
        gen_pins = 2'($urandom_range(3));         // may skip a state: no count change
        send_word(pin_word(gen_pins, 1'b1));
        done++;
      end
      // halfway through, let the pipe run completely dry once
      if (!paused && done >= n / 2) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    int phase;
    cur_speed     = SPEED_RESET;
    cur_objw      = OBJW_RESET;
    settings_used = 1;
    gen_pins      = '0;
    send_idle_pct = 35;
    recv_idle_pct = 79;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed words, reset settings: step 3, object width 16, position 25 ----
    send_word(pin_word(2'b11, 1'b0));             // inactive: nothing moves
    send_word(pin_word(2'b10, 1'b1));             // three up edges -> step up to 28
    send_word(pin_word(2'b11, 1'b1));
    send_word(pin_word(2'b01, 1'b1));
    send_word(pin_word(2'b00, 1'b1));             // count back to +1
    send_word(pin_word(2'b01, 1'b1));             // four down edges -> step down to 25
    send_word(pin_word(2'b11, 1'b1));
    send_word(pin_word(2'b10, 1'b1));
    send_word(pin_word(2'b00, 1'b1));
    send_word(load_word(8'h7F));                  // most positive load
    send_word(load_word(8'h80));                  // most negative load
    send_word(pin_word(2'b01, 1'b1));             // down at -128: held below bottom limit
    send_word(pin_word(2'b11, 1'b1));
    send_word(pin_word(2'b10, 1'b1));
    send_word(load_word(8'd61));
    send_word(pin_word(2'b11, 1'b1));             // up at 61 with width 16: held at top
    send_word(pin_word(2'b01, 1'b1));
    send_word(pin_word(2'b00, 1'b1));
    send_word(load_word(8'd45));                  // 45 + 16 = 61, just allowed
    send_word(pin_word(2'b10, 1'b1));
    send_word(pin_word(2'b11, 1'b1));
    send_word(pin_word(2'b01, 1'b1));
    send_word(pin_word(2'b10, 1'b1));             // 01 -> 10 skips a state: no change
    send_word(load_word(8'd3));                   // exactly at bottom limit
    send_word(pin_word(2'b00, 1'b1));             // down edges from 10 -> step to 0
    send_word(pin_word(2'b01, 1'b1));
    send_word(pin_word(2'b11, 1'b1));
    gen_pins = 2'b11;

    // ---- random phases, each under its own register setting ----
    // idle mix: sender 35 / receiver 79, then swapped, then no idling at all
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 79;
      end else if (phase < 4) begin
        send_idle_pct = 79;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase > 0) begin
        drain();
        case (phase)
          1:       write_regs(4'd0, 6'd0, 1'b0);            // smallest step, widest room
          2:       write_regs(4'd15, 6'd63, 1'b0);          // largest both fields allow
          3:       write_regs(4'd10, 6'd61, 1'b0);          // top of the usual range
          4:       write_regs(4'd7, 6'd30, 1'b1);           // plus writes to spare indexes
          default: write_regs(4'($urandom_range(15)), 6'($urandom_range(63)), 1'b0);
        endcase
      end
      run_random(RANDOM_PER_PHASE);
    end

    drain();
    repeat (4) @(posedge clk);

    $display("covered %0d words under %0d register settings and three idle mixes",
             words_in, settings_used);
    $display("tracker stepped up %0d times, down %0d times, held at a limit %0d times",
             up_moves, down_moves, held_steps);
    if (fail_count == 0)
      $display("quadrature_encoder_position_tracker_top: match");
    else
      $display("quadrature_encoder_position_tracker_top: mismatch");
    $finish;
  end

  // Watchdog: about 1000 words, even under the 79% stalls, take some tens of
  // microseconds; 2 ms leaves a wide margin.
  initial begin
    #2_000_000;
    $display("quadrature_encoder_position_tracker_top: mismatch");
    $finish;
  end

endmodule
